// ===== hdl/xcpd_pkg.sv =====
// Shared types and codes for the XOR-checked packet deframer.
package xcpd_pkg;

    localparam int ByteW  = 8;
    localparam int EventW = 2;
    localparam int CfgAddrW = 1;

    localparam logic [ByteW-1:0] StartByteReset  = 8'd170;
    localparam logic [ByteW-1:0] MaxPayloadReset = 8'd128;

    localparam logic [CfgAddrW-1:0] REG_START_BYTE  = 1'd0;
    localparam logic [CfgAddrW-1:0] REG_MAX_PAYLOAD = 1'd1;

    localparam logic [EventW-1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [EventW-1:0] EV_GOOD     = 2'd1;
    localparam logic [EventW-1:0] EV_BAD      = 2'd2;
    localparam logic [EventW-1:0] EV_OVERFLOW = 2'd3;

    typedef enum logic [4:0] {
        PH_START   = 5'b00001,
        PH_CMD     = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CHECK   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [ByteW-1:0] start_byte;
        logic [ByteW-1:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [EventW-1:0] event_res;
        logic [ByteW-1:0]  data;
        logic [ByteW-1:0]  position;
        logic [ByteW-1:0]  command;
        logic [ByteW-1:0]  length;
    } result_t;

endpackage

// ===== hdl/xcpd_parser.sv =====
// Frame hunting state machine with running XOR check and event generation.
module xcpd_parser
    import xcpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             beat_accept,
    input  logic [ByteW-1:0] rx_data,
    input  cfg_t             cfg,
    output result_t          result
);

    phase_t           phase_reg, phase_next;
    logic [ByteW-1:0] command_reg, command_next;
    logic [ByteW-1:0] length_reg, length_next;
    logic [ByteW-1:0] index_reg, index_next;
    logic [ByteW-1:0] check_reg, check_next;
    logic [ByteW-1:0] index_inc;

    assign index_inc = index_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        index_next   = index_reg;
        check_next   = check_reg;

        result.valid     = 1'b0;
        result.event_res = EV_PAYLOAD;
        result.data      = rx_data;
        result.position  = index_reg;
        result.command   = command_reg;
        result.length    = length_reg;

        unique case (phase_reg)
            PH_CMD:
            begin
                command_next = rx_data;
                check_next   = rx_data;
                phase_next   = PH_LEN;
            end
            PH_LEN:
            begin
                length_next = rx_data;
                check_next  = check_reg ^ rx_data;
                index_next  = '0;
                phase_next  = (rx_data != '0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD:
            begin
                result.valid = 1'b1;
                if (index_reg < cfg.max_payload)
                begin
                    check_next = check_reg ^ rx_data;
                    index_next = index_inc;
                    if (index_inc >= length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                else
                begin
                    // drop the frame, resume hunting
                    result.event_res = EV_OVERFLOW;
                    phase_next       = PH_START;
                end
            end
            PH_CHECK:
            begin
                result.valid     = 1'b1;
                result.event_res = (rx_data == check_reg) ? EV_GOOD : EV_BAD;
                phase_next       = PH_START;
            end
            default:
            begin
                phase_next = (rx_data == cfg.start_byte) ? PH_CMD : PH_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            command_reg <= '0;
            length_reg  <= '0;
            index_reg   <= '0;
            check_reg   <= '0;
        end
        else if (beat_accept)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            index_reg   <= index_next;
            check_reg   <= check_next;
        end
    end

endmodule

// ===== hdl/xcpd_out_reg.sv =====
// Output register holding one result beat for the master side.
module xcpd_out_reg
    import xcpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    input  logic    take,
    output logic    space,
    output logic    valid,
    output result_t held
);

    logic    valid_reg, valid_next;
    result_t held_reg;

    // accept a new beat when empty or when the held one leaves this cycle
    assign space = !valid_reg || take;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= result;
        end
    end

    assign valid = valid_reg;
    assign held  = held_reg;

endmodule

// ===== hdl/xor_checked_packet_deframer_top.sv =====
// Top level of the XOR-checked packet deframer.
//
// Slave side: one received byte per beat on s_tdata. Frames are
// start byte, command, length, payload bytes, check byte; the check byte
// is the XOR of command, length and every payload byte.
// Master side: one event beat per payload byte (tagged with its index),
// one verdict beat (good or mismatch) per check byte, and one overflow
// beat when a payload byte arrives past max_payload. Start, command and
// length bytes and bytes outside a frame produce no beat.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr
// (0 start_byte, 1 max_payload); write only while the block is idle.
// An event beat appears in the cycle after its input beat is accepted.
// Throughput: one byte per cycle while the master does not stall, set by the single output register.
// A stalled master holds the output beat; s_tready drops only while that
// beat is held and m_tready is low.
// Reset: hunting for the start byte, start_byte 170, max_payload 128,
// output empty.
module xor_checked_packet_deframer_top
    import xcpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [ByteW-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_data
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [7:0] data, [15:8] position,
                                           // [23:16] command, [31:24] length
    output logic [EventW-1:0]   m_tuser    // [1:0] event_res
);

    cfg_t    cfg_reg;
    result_t result;
    result_t held;
    logic    beat_accept;
    logic    space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= StartByteReset;
            cfg_reg.max_payload <= MaxPayloadReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_START_BYTE:  cfg_reg.start_byte  <= cfg_wdata;
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_wdata;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign s_tready    = space;
    assign beat_accept = s_tvalid && s_tready;

    xcpd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_accept (beat_accept),
        .rx_data     (s_tdata),
        .cfg         (cfg_reg),
        .result      (result)
    );

    xcpd_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (beat_accept && result.valid),
        .result (result),
        .take   (m_tready),
        .space  (space),
        .valid  (m_tvalid),
        .held   (held)
    );

    assign m_tdata = {held.length, held.command, held.position, held.data};
    assign m_tuser = held.event_res;

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // a new output beat only follows an accepted input beat
    a_beat_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("output beat without input beat");

    // a verdict comes only after exactly the declared payload
    a_verdict_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_GOOD || m_tuser == EV_BAD))
            |-> (held.position == held.length))
        else $error("verdict with payload count not equal to length");

    // a payload beat lies inside the declared length
    a_payload_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == EV_PAYLOAD) |-> (held.position < held.length))
        else $error("payload beat beyond declared length");

endmodule
